>>> rtl/gyro_temp_bias_compensator_top_macros.svh
// Assertion macros for the gyro bias compensator checker.
`ifndef GYRO_TEMP_BIAS_COMPENSATOR_TOP_MACROS_SVH
`define GYRO_TEMP_BIAS_COMPENSATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GTBC_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("gtbc check failed");

// next-cycle implication
`define GTBC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("gtbc check failed");

`endif

>>> rtl/gtbc_pkg.sv
// Package: types and constants of the gyro bias compensator.
`timescale 1ns / 1ps
`default_nettype none
package gtbc_pkg;

  // quotient bits of the confidence divider (max quotient 29491)
  localparam int QW = 15;

  localparam logic [15:0] CONF_ONE       = 16'd65535;
  localparam logic [15:0] CONF_HARD_TOP  = 16'd52428;
  localparam logic [15:0] CONF_FLOOR     = 16'd13107;
  localparam logic [14:0] CONF_SOFT_SPAN = 15'd13107;
  localparam logic [14:0] CONF_HARD_SPAN = 15'd29491;

  localparam logic [2:0] REG_BIAS  = 3'd0;
  localparam logic [2:0] REG_SLOPE = 3'd1;
  localparam logic [2:0] REG_TREF  = 3'd2;
  localparam logic [2:0] REG_TMIN  = 3'd3;
  localparam logic [2:0] REG_TMAX  = 3'd4;
  localparam logic [2:0] REG_SOFT  = 3'd5;
  localparam logic [2:0] REG_HARD  = 3'd6;
  localparam logic [2:0] REG_MODE  = 3'd7;

  // range status of one word
  typedef struct packed {
    logic        has_range;
    logic        oor;
    logic        soft_ex;
    logic        hard_ex;
    logic [16:0] distance;
    logic [15:0] conf_fix;
    logic        use_div;
  } gtbc_rng_t;

  // everything that rides alongside the divider
  typedef struct packed {
    logic [2:0][31:0] corr;
    logic [2:0][31:0] bias;
    gtbc_rng_t        rng;
  } gtbc_side_t;

endpackage
`default_nettype wire

>>> rtl/gyro_temp_bias_compensator_top.sv
// Top level: linear temperature bias compensation of a three-axis gyro sample.
`timescale 1ns / 1ps
`default_nettype none
// One word in and one word out per cycle. out_valid rises after the
// accepting edge, through 21 register stages: the input capture, four stages
// of range check, slope multiply, bias add and saturating subtract, fifteen
// stages of the confidence divider (one quotient bit each), and the output
// register. The whole pipeline moves as one; it holds only while the output
// word is stalled, and in_stall follows that. Bias per axis is ref_bias plus
// slope*(T - ref_temp) floored to 2^-20 rad/s when the model is valid and
// enabled, ref_bias alone otherwise, and zero when the bias is not valid.
// Confidence in the soft and hard zones is a linear ramp computed by the
// divider against the margin register(s). Config writes land in one cycle
// and must only happen while the pipeline is empty; reg index 0..7 follows
// bias, slope, ref_temp, cal_min, cal_max, soft, hard, mode.
module gyro_temp_bias_compensator_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [59:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_raw_x,
  input  wire logic signed [31:0] in_raw_y,
  input  wire logic signed [31:0] in_raw_z,
  input  wire logic signed [15:0] in_temperature,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_corr_x,
  output logic signed [31:0]      out_corr_y,
  output logic signed [31:0]      out_corr_z,
  output logic signed [31:0]      out_bias_out_x,
  output logic signed [31:0]      out_bias_out_y,
  output logic signed [31:0]      out_bias_out_z,
  output logic                    out_has_range,
  output logic                    out_out_of_range,
  output logic                    out_soft_extrap,
  output logic                    out_hard_extrap,
  output logic [16:0]             out_range_distance,
  output logic [15:0]             out_confidence
);

  // ---------------- config registers ----------------
  logic [59:0] bias_pack_r, slope_pack_r;
  logic [15:0] ref_temp_r, tmin_r, tmax_r, soft_r, hard_r;
  logic [2:0]  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_pack_r  <= '0;
      slope_pack_r <= '0;
      ref_temp_r   <= 16'd6400;
      tmin_r       <= '0;
      tmax_r       <= '0;
      soft_r       <= '0;
      hard_r       <= '0;
      mode_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        gtbc_pkg::REG_BIAS:  bias_pack_r  <= cfg_data;
        gtbc_pkg::REG_SLOPE: slope_pack_r <= cfg_data;
        gtbc_pkg::REG_TREF:  ref_temp_r   <= cfg_data[15:0];
        gtbc_pkg::REG_TMIN:  tmin_r       <= cfg_data[15:0];
        gtbc_pkg::REG_TMAX:  tmax_r       <= cfg_data[15:0];
        gtbc_pkg::REG_SOFT:  soft_r       <= cfg_data[15:0];
        gtbc_pkg::REG_HARD:  hard_r       <= cfg_data[15:0];
        gtbc_pkg::REG_MODE:  mode_r       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic bvalid, mvalid, slope_on;
  assign bvalid   = mode_r[0];
  assign mvalid   = mode_r[1];
  assign slope_on = mode_r[0] & mode_r[1] & mode_r[2];

  // global advance: move unless the output word is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---------------- stage A: capture ----------------
  logic                   a_vld_r;
  logic [2:0][31:0]       a_raw_r;
  logic signed [15:0]     a_t_r;

  // ---------------- stage B: range check, dT ----------------
  logic                   b_vld_r;
  logic [2:0][31:0]       b_raw_r;
  logic signed [16:0]     b_dt_r;
  logic [16:0]            b_dsel_r;
  logic [14:0]            b_k_r;
  logic [15:0]            b_den_r;
  gtbc_pkg::gtbc_rng_t    b_rng_r;

  logic signed [16:0]     dt_nxt, lo_diff, hi_diff;
  logic                   hr_nxt, soft_zone, hard_zone;
  logic [16:0]            dist_nxt, dsel_nxt;
  logic [14:0]            k_nxt;
  logic [15:0]            den_nxt;
  gtbc_pkg::gtbc_rng_t    rng_nxt;

  always_comb begin
    dt_nxt  = {a_t_r[15], a_t_r} - {ref_temp_r[15], ref_temp_r};
    lo_diff = {tmin_r[15], tmin_r} - {a_t_r[15], a_t_r};
    hi_diff = {a_t_r[15], a_t_r} - {tmax_r[15], tmax_r};
    hr_nxt  = bvalid && mvalid && ($signed(tmax_r) > $signed(tmin_r));
    dist_nxt = '0;
    if (hr_nxt) begin
      if (a_t_r < $signed(tmin_r)) begin
        dist_nxt = lo_diff;
      end else if (a_t_r > $signed(tmax_r)) begin
        dist_nxt = hi_diff;
      end
    end
    soft_zone = (soft_r != 16'd0) && (dist_nxt <= {1'b0, soft_r});
    hard_zone = !soft_zone && (hard_r > soft_r) && (dist_nxt <= {1'b0, hard_r});
    rng_nxt.has_range = hr_nxt;
    rng_nxt.oor       = dist_nxt != 17'd0;
    rng_nxt.distance  = dist_nxt;
    rng_nxt.soft_ex   = rng_nxt.oor && (soft_zone || hard_zone);
    rng_nxt.hard_ex   = rng_nxt.oor && !soft_zone && !hard_zone;
    rng_nxt.use_div   = rng_nxt.soft_ex;
    dsel_nxt = dist_nxt;
    k_nxt    = gtbc_pkg::CONF_SOFT_SPAN;
    den_nxt  = soft_r;
    if (!rng_nxt.oor) begin
      rng_nxt.conf_fix = gtbc_pkg::CONF_ONE;
    end else if (soft_zone) begin
      rng_nxt.conf_fix = gtbc_pkg::CONF_ONE;
    end else if (hard_zone) begin
      rng_nxt.conf_fix = gtbc_pkg::CONF_HARD_TOP;
      dsel_nxt = dist_nxt - {1'b0, soft_r};
      k_nxt    = gtbc_pkg::CONF_HARD_SPAN;
      den_nxt  = hard_r - soft_r;
    end else begin
      rng_nxt.conf_fix = gtbc_pkg::CONF_FLOOR;
    end
  end

  // ---------------- stage C: multiplies ----------------
  logic                   c_vld_r;
  logic [2:0][31:0]       c_raw_r;
  logic [2:0][36:0]       c_prod_r;
  logic [31:0]            c_num_r;
  logic [15:0]            c_den_r;
  gtbc_pkg::gtbc_rng_t    c_rng_r;

  logic [2:0][36:0]       prod_nxt;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = 37'($signed(slope_pack_r[20*k +: 20]) * b_dt_r);
    end
  end

  // ---------------- stage D: bias ----------------
  logic                   d_vld_r;
  logic [2:0][31:0]       d_raw_r;
  logic [2:0][21:0]       d_bias_r;
  logic [31:0]            d_num_r;
  logic [15:0]            d_den_r;
  gtbc_pkg::gtbc_rng_t    d_rng_r;

  logic [2:0][21:0]       bias_nxt;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bias_nxt[k] = '0;
      if (bvalid) begin
        bias_nxt[k] = 22'($signed(bias_pack_r[20*k +: 20]));
        if (slope_on) begin
          // floor shift by 16: keep the upper bits
          bias_nxt[k] = bias_nxt[k] + 22'($signed(c_prod_r[k][36:16]));
        end
      end
    end
  end

  // ---------------- stage E: saturating subtract ----------------
  logic                   e_vld_r;
  logic [2:0][31:0]       e_corr_r;
  logic [2:0][21:0]       e_bias_r;
  logic [31:0]            e_num_r;
  logic [15:0]            e_den_r;
  gtbc_pkg::gtbc_rng_t    e_rng_r;

  logic [2:0][31:0]       corr_nxt;
  logic signed [32:0]     diff [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({d_raw_r[k][31], d_raw_r[k]}) - 33'($signed(d_bias_r[k]));
      if (diff[k][32] != diff[k][31]) begin
        corr_nxt[k] = diff[k][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        corr_nxt[k] = diff[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_raw_r  <= {in_raw_z, in_raw_y, in_raw_x};
      a_t_r    <= in_temperature;
      b_raw_r  <= a_raw_r;
      b_dt_r   <= dt_nxt;
      b_dsel_r <= dsel_nxt;
      b_k_r    <= k_nxt;
      b_den_r  <= den_nxt;
      b_rng_r  <= rng_nxt;
      c_raw_r  <= b_raw_r;
      c_prod_r <= prod_nxt;
      c_num_r  <= 32'(b_k_r * b_dsel_r);
      c_den_r  <= b_den_r;
      c_rng_r  <= b_rng_r;
      d_raw_r  <= c_raw_r;
      d_bias_r <= bias_nxt;
      d_num_r  <= c_num_r;
      d_den_r  <= c_den_r;
      d_rng_r  <= c_rng_r;
      e_corr_r <= corr_nxt;
      e_bias_r <= d_bias_r;
      e_num_r  <= d_num_r;
      e_den_r  <= d_den_r;
      e_rng_r  <= d_rng_r;
    end
  end

  // ---------------- confidence divider ----------------
  gtbc_pkg::gtbc_side_t   side_in, side_out;
  logic                   dv_vld;
  logic [gtbc_pkg::QW-1:0] dv_quo;

  always_comb begin
    side_in.corr = e_corr_r;
    for (int k = 0; k < 3; k++) begin
      side_in.bias[k] = 32'($signed(e_bias_r[k]));
    end
    side_in.rng = e_rng_r;
  end

  gtbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (e_vld_r),
    .in_num   (e_num_r),
    .in_den   (e_den_r),
    .in_side  (side_in),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (side_out)
  );

  // ---------------- output register ----------------
  logic                 out_valid_r;
  gtbc_pkg::gtbc_side_t out_side_r;
  logic [15:0]          out_conf_r, conf_nxt;

  assign conf_nxt = side_out.rng.use_div ?
                    side_out.rng.conf_fix - 16'(dv_quo) : side_out.rng.conf_fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side_r <= side_out;
      out_conf_r <= conf_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_corr_x         = out_side_r.corr[0];
  assign out_corr_y         = out_side_r.corr[1];
  assign out_corr_z         = out_side_r.corr[2];
  assign out_bias_out_x     = out_side_r.bias[0];
  assign out_bias_out_y     = out_side_r.bias[1];
  assign out_bias_out_z     = out_side_r.bias[2];
  assign out_has_range      = out_side_r.rng.has_range;
  assign out_out_of_range   = out_side_r.rng.oor;
  assign out_soft_extrap    = out_side_r.rng.soft_ex;
  assign out_hard_extrap    = out_side_r.rng.hard_ex;
  assign out_range_distance = out_side_r.rng.distance;
  assign out_confidence     = out_conf_r;

endmodule
`default_nettype wire

>>> rtl/gtbc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
`timescale 1ns / 1ps
`default_nettype none
module gtbc_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire logic [31:0]            in_num,
  input  wire logic [15:0]            in_den,
  input  wire gtbc_pkg::gtbc_side_t   in_side,
  output logic                        out_vld,
  output logic [gtbc_pkg::QW-1:0]     out_quo,
  output gtbc_pkg::gtbc_side_t        out_side
);

  localparam int QW = gtbc_pkg::QW;

  logic                 vld_r  [QW];
  logic [31:0]          rem_r  [QW];
  logic [15:0]          den_r  [QW];
  logic [QW-1:0]        quo_r  [QW];
  gtbc_pkg::gtbc_side_t side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stg
    localparam int BIT = QW - 1 - i;
    logic                 vld_in;
    logic [31:0]          rem_in;
    logic [15:0]          den_in;
    logic [QW-1:0]        quo_in;
    gtbc_pkg::gtbc_side_t side_in;
    logic [31:0]          shd;
    logic                 ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign shd = {16'd0, den_in} << BIT;
    assign ge  = rem_in >= shd;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? rem_in - shd : rem_in;
        den_r[i]  <= den_in;
        quo_r[i]  <= quo_in | (ge ? ({{(QW-1){1'b0}}, 1'b1} << BIT) : '0);
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule
`default_nettype wire

>>> rtl/gtbc_chk.sv
// Port-level checker for the gyro bias compensator, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "gyro_temp_bias_compensator_top_macros.svh"
module gtbc_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_has_range,
  input wire logic        out_out_of_range,
  input wire logic        out_soft_extrap,
  input wire logic        out_hard_extrap,
  input wire logic [16:0] out_range_distance,
  input wire logic [15:0] out_confidence
);

  `GTBC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
  `GTBC_ASSERT(a_oor_needs_range, out_valid && out_out_of_range, out_has_range)
  `GTBC_ASSERT(a_one_zone, out_valid, !(out_soft_extrap && out_hard_extrap))
  `GTBC_ASSERT(a_inside, out_valid && !out_out_of_range,
               out_range_distance == 17'd0 && out_confidence == 16'hFFFF)
  `GTBC_ASSERT(a_hard_floor, out_valid && out_hard_extrap, out_confidence == 16'd13107)

endmodule

bind gyro_temp_bias_compensator_top gtbc_chk u_chk (.*);
`default_nettype wire

>>> bench/gyro_temp_bias_compensator_top_tb.sv
// Testbench for the gyro temperature bias compensator: a linear-model predictor and a scoreboard.
`timescale 1ns / 1ps
`default_nettype none

// Predicted result of one word.
typedef struct {
  logic signed [31:0] corr [3];
  logic signed [31:0] bias [3];
  logic               has_range;
  logic               oor;
  logic               soft_ex;
  logic               hard_ex;
  logic [16:0]        distance;
  logic [15:0]        conf;
} comp_result_t;

class bias_scoreboard;
  // register copy
  logic [59:0] bias_pack;
  logic [59:0] slope_pack;
  logic signed [15:0] t_ref;
  logic signed [15:0] t_min;
  logic signed [15:0] t_max;
  logic [15:0] soft_m;
  logic [15:0] hard_m;
  logic [2:0] mode;
  comp_result_t pending[$];
  int mismatches;

  function new();
    bias_pack = '0; slope_pack = '0; t_ref = 16'sd6400; t_min = '0; t_max = '0;
    soft_m = '0; hard_m = '0; mode = '0; mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [59:0] data);
    case (idx)
      gtbc_pkg::REG_BIAS:  bias_pack = data;
      gtbc_pkg::REG_SLOPE: slope_pack = data;
      gtbc_pkg::REG_TREF:  t_ref = data[15:0];
      gtbc_pkg::REG_TMIN:  t_min = data[15:0];
      gtbc_pkg::REG_TMAX:  t_max = data[15:0];
      gtbc_pkg::REG_SOFT:  soft_m = data[15:0];
      gtbc_pkg::REG_HARD:  hard_m = data[15:0];
      default:             mode = data[2:0];
    endcase
  endfunction

  function void note_sample(logic signed [31:0] rx, logic signed [31:0] ry,
                            logic signed [31:0] rz, logic signed [15:0] temp);
    comp_result_t r;
    longint raw [3];
    longint b, sl, prod, dt, d, soft_lim, hard_lim, diff;
    raw[0] = rx; raw[1] = ry; raw[2] = rz;
    dt = longint'(temp) - longint'(t_ref);
    for (int k = 0; k < 3; k++) begin
      b = 0;
      if (mode[0]) begin
        b = longint'($signed(bias_pack[20*k +: 20]));
        if (mode[1] && mode[2]) begin
          sl = longint'($signed(slope_pack[20*k +: 20]));
          prod = sl * dt;
          b += prod >>> 16;   // floor
        end
      end
      diff = raw[k] - b;
      if (diff > 64'sd2147483647) diff = 64'sd2147483647;
      if (diff < -64'sd2147483648) diff = -64'sd2147483648;
      r.corr[k] = diff[31:0];
      r.bias[k] = b[31:0];
    end
    soft_lim = soft_m;
    hard_lim = (hard_m > soft_m) ? hard_m : soft_m;
    d = 0;
    r.has_range = mode[0] && mode[1] && (t_max > t_min);
    if (r.has_range) begin
      if (temp < t_min) d = longint'(t_min) - temp;
      else if (temp > t_max) d = longint'(temp) - t_max;
    end
    r.oor = r.has_range && d > 0;
    r.soft_ex = 0; r.hard_ex = 0; r.conf = 16'd65535;
    if (r.oor) begin
      if (soft_lim > 0 && d <= soft_lim) begin
        r.soft_ex = 1;
        r.conf = 16'(65535 - (13107 * d) / soft_lim);
      end else if (hard_lim > soft_lim && d <= hard_lim) begin
        r.soft_ex = 1;
        r.conf = 16'(52428 - (29491 * (d - soft_lim)) / (hard_lim - soft_lim));
      end else begin
        r.hard_ex = 1;
        r.conf = 16'd13107;
      end
    end
    r.distance = d[16:0];
    pending.push_back(r);
  endfunction

  function void check_result(comp_result_t a);
    comp_result_t e;
    bit bad;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected output word");
      return;
    end
    e = pending.pop_front();
    bad = 0;
    for (int k = 0; k < 3; k++)
      if (a.corr[k] !== e.corr[k] || a.bias[k] !== e.bias[k]) bad = 1;
    if (a.has_range !== e.has_range || a.oor !== e.oor || a.soft_ex !== e.soft_ex ||
        a.hard_ex !== e.hard_ex || a.distance !== e.distance || a.conf !== e.conf) bad = 1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: exp corr %0d %0d %0d bias %0d %0d %0d rng %b%b%b%b d %0d c %0d",
                 e.corr[0], e.corr[1], e.corr[2], e.bias[0], e.bias[1], e.bias[2],
                 e.has_range, e.oor, e.soft_ex, e.hard_ex, e.distance, e.conf);
        $display("       act corr %0d %0d %0d bias %0d %0d %0d rng %b%b%b%b d %0d c %0d",
                 a.corr[0], a.corr[1], a.corr[2], a.bias[0], a.bias[1], a.bias[2],
                 a.has_range, a.oor, a.soft_ex, a.hard_ex, a.distance, a.conf);
      end
    end
  endfunction
endclass

module gyro_temp_bias_compensator_top_tb;

  localparam int LATENCY = 21;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [59:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [31:0] in_raw_x, in_raw_y, in_raw_z;
  logic signed [15:0] in_temperature;
  logic out_valid, out_stall;
  logic signed [31:0] out_corr_x, out_corr_y, out_corr_z;
  logic signed [31:0] out_bias_out_x, out_bias_out_y, out_bias_out_z;
  logic out_has_range, out_out_of_range, out_soft_extrap, out_hard_extrap;
  logic [16:0] out_range_distance;
  logic [15:0] out_confidence;

  bias_scoreboard sb;
  bit long_hold;      // forces the receiver to stall for a long stretch
  int idle_cycles;

  gyro_temp_bias_compensator_top uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Output side: stall pattern plus the long hold-off; sample at rising edge.
  initial begin
    int mode_sel;
    out_stall = 0;
    forever begin
      @(negedge clk);
      mode_sel = int'(($time / 4000) % 3);   // rotate stall behavior over the run
      if (long_hold) out_stall <= 1;
      else if (mode_sel == 0) out_stall <= 0;
      else if (mode_sel == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  always @(posedge clk) begin
    comp_result_t a;
    if (rst_n && out_valid && !out_stall) begin
      a.corr[0] = out_corr_x; a.corr[1] = out_corr_y; a.corr[2] = out_corr_z;
      a.bias[0] = out_bias_out_x; a.bias[1] = out_bias_out_y; a.bias[2] = out_bias_out_z;
      a.has_range = out_has_range; a.oor = out_out_of_range;
      a.soft_ex = out_soft_extrap; a.hard_ex = out_hard_extrap;
      a.distance = out_range_distance; a.conf = out_confidence;
      sb.check_result(a);
    end
  end

  // Watchdog: cycles with no word accepted on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || long_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [59:0] data);
    @(negedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Present one word; returns at the falling edge after acceptance with valid still high.
  task automatic send_word(logic signed [31:0] rx, logic signed [31:0] ry,
                           logic signed [31:0] rz, logic signed [15:0] temp);
    in_valid <= 1;
    in_raw_x <= rx; in_raw_y <= ry; in_raw_z <= rz; in_temperature <= temp;
    do @(posedge clk); while (in_stall);
    sb.note_sample(rx, ry, rz, temp);
    @(negedge clk);
  endtask

  task automatic gap(int n);
    in_valid <= 0;
    repeat (n) @(negedge clk);
  endtask

  // Wait until every expected word has arrived, then let the pipe settle.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 4000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  // Temperatures mostly near the calibrated window so every zone is hit.
  function automatic logic [15:0] rand_temp();
    int lo, hi, span;
    lo = sb.t_min; hi = sb.t_max;
    span = sb.hard_m + 64;
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return 16'h8000;
      2: return 16'h7FFF;
      3, 4: return 16'(hi + $urandom_range(0, span));
      5, 6: return 16'(lo - $urandom_range(0, span));
      default: return 16'(lo + $urandom_range(0, (hi > lo) ? hi - lo : 0));
    endcase
  endfunction

  task automatic random_setting(bit extreme);
    if (extreme) begin
      write_cfg(gtbc_pkg::REG_BIAS, {$urandom_range(0, 1) ? 20'h80000 : 20'h7FFFF,
                                     20'h80000, 20'h7FFFF});
      write_cfg(gtbc_pkg::REG_SLOPE, {$urandom_range(0, 1) ? 20'h7FFFF : 20'h80000,
                                      20'h7FFFF, 20'h80000});
      write_cfg(gtbc_pkg::REG_TREF, 60'($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF));
      write_cfg(gtbc_pkg::REG_TMIN, 60'(16'h8000));
      write_cfg(gtbc_pkg::REG_TMAX, 60'(16'h7FFF));
      write_cfg(gtbc_pkg::REG_SOFT, 60'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000));
      write_cfg(gtbc_pkg::REG_HARD, 60'(16'hFFFF));
    end else begin
      write_cfg(gtbc_pkg::REG_BIAS, 60'({$urandom, $urandom}));
      write_cfg(gtbc_pkg::REG_SLOPE, 60'({$urandom, $urandom}));
      write_cfg(gtbc_pkg::REG_TREF, 60'($urandom));
      write_cfg(gtbc_pkg::REG_TMIN, 60'(16'($urandom_range(0, 20000) - 10000)));
      write_cfg(gtbc_pkg::REG_TMAX, 60'(16'($urandom_range(0, 20000) - 8000)));
      write_cfg(gtbc_pkg::REG_SOFT, 60'($urandom_range(0, 3) == 0 ? 16'd0
                                        : 16'($urandom_range(1, 3000))));
      write_cfg(gtbc_pkg::REG_HARD, 60'($urandom_range(0, 3) == 0
                                        ? 16'($urandom_range(0, 2000))
                                        : 16'($urandom_range(0, 8000))));
    end
    write_cfg(gtbc_pkg::REG_MODE, 60'($urandom_range(0, 3) == 0 ? 3'($urandom) : 3'b111));
  endtask

  initial begin
    int burst;
    sb = new();
    rst_n = 0; cfg_we = 0; cfg_idx = '0; cfg_data = '0;
    in_valid = 0; in_raw_x = '0; in_raw_y = '0; in_raw_z = '0; in_temperature = '0;
    long_hold = 0; idle_cycles = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: reset settings, then a known window with soft and hard zones.
    send_word(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 16'sh7FFF);
    drain();
    write_cfg(gtbc_pkg::REG_BIAS, {20'h80000, 20'h7FFFF, 20'h00001});
    write_cfg(gtbc_pkg::REG_SLOPE, {20'h7FFFF, 20'h80000, 20'hFFFFF});
    write_cfg(gtbc_pkg::REG_TREF, 60'd6400);
    write_cfg(gtbc_pkg::REG_TMIN, 60'd0);
    write_cfg(gtbc_pkg::REG_TMAX, 60'd12800);
    write_cfg(gtbc_pkg::REG_SOFT, 60'd512);
    write_cfg(gtbc_pkg::REG_HARD, 60'd1536);
    write_cfg(gtbc_pkg::REG_MODE, 60'd7);
    send_word(32'sh7FFF_FFFF, 32'sh8000_0000, -1, 16'sh8000);
    send_word(32'sh8000_0000, 32'sh7FFF_FFFF, 1, 16'sh7FFF);
    send_word(5, -5, 0, 16'sd6400);
    send_word(0, 0, 0, 16'sd13056);   // soft zone
    send_word(0, 0, 0, 16'sd13312);   // soft edge
    send_word(0, 0, 0, 16'sd13800);   // hard zone
    send_word(0, 0, 0, -16'sd1536);   // hard edge
    send_word(0, 0, 0, -16'sd1537);   // beyond all margins
    send_word(0, 0, 0, 16'sd0);
    drain();
    // Zero soft margin: hard zone starts at the edge.
    write_cfg(gtbc_pkg::REG_SOFT, 60'd0);
    send_word(1, 2, 3, 16'sd12900);
    send_word(1, 2, 3, -16'sd2000);
    drain();
    // Hard not above soft: past soft is hard extrapolation.
    write_cfg(gtbc_pkg::REG_SOFT, 60'd600);
    write_cfg(gtbc_pkg::REG_HARD, 60'd100);
    send_word(1, 2, 3, 16'sd13100);
    send_word(1, 2, 3, 16'sd13500);
    drain();
    // Inverted range; then model valid with bias invalid; then bias valid alone; then model only off.
    write_cfg(gtbc_pkg::REG_TMIN, 60'd12800);
    write_cfg(gtbc_pkg::REG_TMAX, 60'd0);
    send_word(7, 7, 7, 16'sh7FFF);
    drain();
    write_cfg(gtbc_pkg::REG_TMIN, 60'd0);
    write_cfg(gtbc_pkg::REG_TMAX, 60'd12800);
    write_cfg(gtbc_pkg::REG_MODE, 60'd6);
    send_word(7, 7, 7, 16'sh7FFF);
    drain();
    write_cfg(gtbc_pkg::REG_MODE, 60'd1);
    send_word(7, 7, 7, 16'sh7FFF);
    drain();
    write_cfg(gtbc_pkg::REG_MODE, 60'd5);
    send_word(7, 7, 7, 16'sh7FFF);
    drain();

    // Random phases with bursts and gaps.
    for (int ph = 0; ph < 10; ph++) begin
      random_setting(ph == 2 || ph == 7);
      for (int n = 0; n < 85; n += burst) begin
        burst = $urandom_range(1, 16);
        for (int i = 0; i < burst; i++)
          send_word(rand_raw(), rand_raw(), rand_raw(), rand_temp());
        if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 6));
      end
      if (ph == 4) begin
        // Long receiver hold-off while words keep coming, to back up the pipe.
        fork
          begin
            long_hold = 1;
            repeat (80) @(negedge clk);
            long_hold = 0;
          end
          for (int i = 0; i < 40; i++)
            send_word(rand_raw(), rand_raw(), rand_raw(), rand_temp());
        join
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
